FILE: rtl/efa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efa_pkg
// Types and constants shared by the extended float adder pipeline.
// ----------------------------------------------------------------------------
package efa_pkg;

  localparam logic [14:0] ExpMax     = 15'h7FFF;
  localparam logic [63:0] IntBit     = 64'h8000_0000_0000_0000;
  localparam logic [63:0] Indefinite = 64'hC000_0000_0000_0000;
  localparam logic [62:0] FracMask   = 63'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic        a_sign;
    logic [14:0] a_exp;
    logic [63:0] a_significand;
    logic        b_sign;
    logic [14:0] b_exp;
    logic [63:0] b_significand;
  } efa_req_t;

  typedef struct packed {
    logic        sum_sign;
    logic [14:0] sum_exponent;
    logic [63:0] sum_significand;
  } efa_rsp_t;

  // stage 1 -> stage 2: aligned operands or an early result
  typedef struct packed {
    logic        done;
    efa_rsp_t    early;
    logic        sub;
    logic        sign;
    logic [14:0] exponent;
    logic [63:0] big_m;
    logic [63:0] small_m;
    logic [5:0]  shamt;
    logic        zero_small;
  } efa_s1_t;

  // stage 2 -> stage 3: raw sum with leading zero count
  typedef struct packed {
    logic        done;
    efa_rsp_t    early;
    logic        sign;
    logic [14:0] exponent;
    logic [63:0] mag;
    logic [6:0]  lz;
  } efa_s2_t;

endpackage

FILE: rtl/extended_float_adder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extended_float_adder
// Truncating adder for 80-bit x87 extended floats.
// ----------------------------------------------------------------------------
// Three register stages (special cases and ordering, align and add with
// leading zero count, normalize) take one request per cycle while the
// output accepts; each result is offered from the normalize stage
// register. A stall at the output holds every full stage while empty
// stages keep filling, and input ready follows output ready
// combinationally through the stage enables.
module extended_float_adder import efa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  efa_req_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output efa_rsp_t out_data_o
);

  efa_s1_t  s1_d, s1_q;
  efa_s2_t  s2_d, s2_q;
  efa_rsp_t r_d, r_q;
  logic     v1_q, v2_q, v3_q, en1, en2, en3;

  efa_align  u_align  (.req_i(in_data_i), .s1_o(s1_d));
  efa_addsub u_addsub (.s1_i(s1_q), .s2_o(s2_d));
  efa_norm   u_norm   (.s2_i(s2_q), .rsp_o(r_d));

  assign en3 = !v3_q || out_ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o  = en1;
  assign out_valid_o = v3_q;
  assign out_data_o  = r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) s1_q <= s1_d;
    if (en2) s2_q <= s2_d;
    if (en3) r_q  <= r_d;
  end

endmodule

FILE: rtl/efa_align.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efa_align
// Special case detection, operand ordering and exponent difference.
// ----------------------------------------------------------------------------
module efa_align import efa_pkg::*; (
  input  efa_req_t req_i,
  output efa_s1_t  s1_o
);

  logic        a_spec, b_spec, a_nan, b_nan, diff, a_big;
  logic [63:0] am, bm;
  logic [15:0] e_inc;
  logic [14:0] d;

  always_comb begin
    am     = {1'b0, req_i.a_significand[63:1]};
    bm     = {1'b0, req_i.b_significand[63:1]};
    a_spec = req_i.a_exp == ExpMax;
    b_spec = req_i.b_exp == ExpMax;
    a_nan  = a_spec && (req_i.a_significand[62:0] & FracMask) != '0;
    b_nan  = b_spec && (req_i.b_significand[62:0] & FracMask) != '0;
    diff   = req_i.a_sign ^ req_i.b_sign;
    e_inc  = {1'b0, req_i.a_exp} + 16'd1;
    a_big  = (req_i.a_exp != req_i.b_exp) ?
             (req_i.a_exp > req_i.b_exp) : (am > bm);
    d      = a_big ? req_i.a_exp - req_i.b_exp
                   : req_i.b_exp - req_i.a_exp;

    s1_o            = '0;
    s1_o.done       = 1'b1;
    s1_o.sub        = diff;
    s1_o.sign       = a_big ? req_i.a_sign : req_i.b_sign;
    s1_o.exponent   = a_big ? req_i.a_exp : req_i.b_exp;
    s1_o.big_m      = a_big ? am : bm;
    s1_o.small_m    = a_big ? bm : am;
    s1_o.shamt      = d[5:0];
    s1_o.zero_small = d > 15'd63;

    priority if (a_nan || (a_spec && !b_spec) ||
                 (a_spec && b_spec && !diff && !b_nan)) begin
      s1_o.early = '{req_i.a_sign, req_i.a_exp, req_i.a_significand};
    end else if (b_nan || (b_spec && !a_spec)) begin
      s1_o.early = '{req_i.b_sign, req_i.b_exp, req_i.b_significand};
    end else if (a_spec && b_spec) begin
      s1_o.early = '{1'b1, ExpMax, Indefinite};
    end else if (am == '0 && bm == '0) begin
      s1_o.early = '{req_i.a_sign & req_i.b_sign, 15'd0, 64'd0};
    end else if (req_i.a_exp == req_i.b_exp && am == bm) begin
      if (diff) begin
        s1_o.early = '0;
      end else if (e_inc >= {1'b0, ExpMax}) begin
        s1_o.early = '{req_i.a_sign, ExpMax, IntBit};
      end else begin
        s1_o.early = '{req_i.a_sign, e_inc[14:0], {am[62:0], 1'b0}};
      end
    end else begin
      s1_o.done = 1'b0;
    end
  end

endmodule

FILE: rtl/efa_addsub.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efa_addsub
// Alignment shift, magnitude add or subtract, leading zero count.
// ----------------------------------------------------------------------------
module efa_addsub import efa_pkg::*; (
  input  efa_s1_t s1_i,
  output efa_s2_t s2_o
);

  logic [63:0] shifted, mag;

  always_comb begin
    shifted = s1_i.zero_small ? 64'd0 : (s1_i.small_m >> s1_i.shamt);
    mag     = s1_i.sub ? s1_i.big_m - shifted : s1_i.big_m + shifted;
    s2_o          = '0;
    s2_o.done     = s1_i.done;
    s2_o.early    = s1_i.early;
    s2_o.sign     = s1_i.sign;
    s2_o.exponent = s1_i.exponent;
    s2_o.mag      = mag;
    s2_o.lz       = 7'd64;
    for (int i = 0; i < 64; i++) begin
      if (mag[i]) s2_o.lz = 7'(63 - i);
    end
  end

endmodule

FILE: rtl/efa_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efa_norm
// Normalizing shift, exponent adjust, overflow and underflow.
// ----------------------------------------------------------------------------
module efa_norm import efa_pkg::*; (
  input  efa_s2_t  s2_i,
  output efa_rsp_t rsp_o
);

  logic signed [17:0] e;

  always_comb begin
    e = $signed({3'b0, s2_i.exponent}) + 18'sd1 - $signed({11'b0, s2_i.lz});
    if (s2_i.done) begin
      rsp_o = s2_i.early;
    end else if (s2_i.mag == '0) begin
      rsp_o = '0;
    end else if (e >= $signed({3'b0, ExpMax})) begin
      rsp_o = '{s2_i.sign, ExpMax, IntBit};
    end else if (e < 18'sd1) begin
      rsp_o = '{s2_i.sign, 15'd0, 64'd0};
    end else begin
      rsp_o = '{s2_i.sign, e[14:0], s2_i.mag << s2_i.lz[5:0]};
    end
  end

endmodule

FILE: rtl/efa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efa_checker
// Port level checks for the extended float adder.
// ----------------------------------------------------------------------------
module efa_checker import efa_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input efa_rsp_t out_data_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  // free output means free input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled with output free");

  // an accepted request shows up as a result when nothing stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i
    |-> out_valid_o)
    else $error("result missing after pipeline latency");

endmodule

bind extended_float_adder efa_checker u_efa_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
);

FILE: tb/sv/extended_float_adder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extended_float_adder_tb
// Drives directed and random operand pairs through the extended float adder
// and checks every sum against a predictor kept in the bench, under random
// idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module extended_float_adder_tb;
  import efa_pkg::*;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  efa_req_t in_data;
  logic     out_valid;
  logic     out_ready;
  efa_rsp_t out_data;

  efa_req_t pending_q[$];
  efa_rsp_t expected_sums_q[$];
  int       n_errors;
  int       send_idle_pct;
  int       recv_idle_pct;
  int       hold_cycles;
  bit       stim_done;
  bit       in_taken;

  extended_float_adder i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic efa_rsp_t pack_sum(logic s, logic [14:0] e, logic [63:0] m);
    efa_rsp_t r;
    r.sum_sign        = s;
    r.sum_exponent    = e;
    r.sum_significand = m;
    return r;
  endfunction

  // predicted truncated sum of one request
  function automatic efa_rsp_t predict_sum(efa_req_t q);
    logic [63:0] am, bm, big_m, small_m, shifted, m;
    logic        diff, a_spec, b_spec, a_big, s;
    int          e, lz;
    logic [15:0] d;
    am = q.a_significand >> 1;
    bm = q.b_significand >> 1;
    diff = q.a_sign ^ q.b_sign;
    a_spec = q.a_exp == ExpMax;
    b_spec = q.b_exp == ExpMax;
    if (a_spec && q.a_significand[62:0] != '0)
      return pack_sum(q.a_sign, q.a_exp, q.a_significand);
    if (b_spec && q.b_significand[62:0] != '0)
      return pack_sum(q.b_sign, q.b_exp, q.b_significand);
    if (a_spec && b_spec) begin
      if (diff) return pack_sum(1'b1, ExpMax, Indefinite);
      return pack_sum(q.a_sign, q.a_exp, q.a_significand);
    end
    if (a_spec) return pack_sum(q.a_sign, q.a_exp, q.a_significand);
    if (b_spec) return pack_sum(q.b_sign, q.b_exp, q.b_significand);
    if (am == 0 && bm == 0) return pack_sum(q.a_sign & q.b_sign, '0, '0);
    if (q.a_exp == q.b_exp && am == bm) begin
      if (diff) return pack_sum(1'b0, '0, '0);
      if (int'(q.a_exp) + 1 >= int'(ExpMax)) return pack_sum(q.a_sign, ExpMax, IntBit);
      return pack_sum(q.a_sign, q.a_exp + 15'd1, am << 1);
    end
    a_big = (q.a_exp != q.b_exp) ? q.a_exp > q.b_exp : am > bm;
    if (a_big) begin
      d = q.a_exp - q.b_exp;
      big_m = am; small_m = bm; e = q.a_exp; s = q.a_sign;
    end else begin
      d = q.b_exp - q.a_exp;
      big_m = bm; small_m = am; e = q.b_exp; s = q.b_sign;
    end
    shifted = (d >= 64) ? '0 : small_m >> d;
    m = diff ? big_m - shifted : big_m + shifted;
    if (m == 0) return pack_sum(1'b0, '0, '0);
    lz = 0;
    while (lz < 64 && !m[63 - lz]) lz++;
    if (lz == 0) e = e + 1;
    else begin
      m = m << lz;
      e = e - (lz - 1);
    end
    if (e >= int'(ExpMax)) return pack_sum(s, ExpMax, IntBit);
    if (e < 1) return pack_sum(s, '0, '0);
    return pack_sum(s, e[14:0], m);
  endfunction

  function automatic logic [63:0] rand_sig();
    logic [63:0] m;
    m = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: m = '0;
      1: m = '1;
      2: m = 64'h1 << $urandom_range(0, 63);
      3: m = m >> $urandom_range(0, 63);
      default: m[63] = 1'b1;
    endcase
    return m;
  endfunction

  function automatic logic [14:0] rand_exp();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return ExpMax;
      2: return ExpMax - 15'($urandom_range(1, 3));
      3: return 15'($urandom_range(1, 3));
      default: return 15'($urandom_range(0, 32767));
    endcase
  endfunction

  task automatic add_req(logic as, logic [14:0] ae, logic [63:0] am,
                         logic bs, logic [14:0] be, logic [63:0] bm);
    efa_req_t q;
    q = {as, ae, am, bs, be, bm};
    pending_q.push_back(q);
  endtask

  // request accepted at this edge: predict and retire it
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      expected_sums_q.push_back(predict_sum(in_data));
      void'(pending_q.pop_front());
    end
    in_taken <= rst_n && in_valid && in_ready;
  end

  // sender: falling-edge drive from the pending queue
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_taken) begin
        in_valid <= 1'b1;
      end else if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= pending_q[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stall plus one long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready   <= 1'b0;
    end else begin
      out_ready <= $urandom_range(0, 99) >= recv_idle_pct;
    end
  end

  always @(posedge clk) begin
    efa_rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_sums_q.size() == 0) begin
        $error("unexpected result %h", out_data);
        n_errors++;
      end else begin
        want = expected_sums_q.pop_front();
        if (out_data.sum_sign !== want.sum_sign) begin
          $error("sum_sign exp %h got %h", want.sum_sign, out_data.sum_sign);
          n_errors++;
        end
        if (out_data.sum_exponent !== want.sum_exponent) begin
          $error("sum_exponent exp %h got %h", want.sum_exponent, out_data.sum_exponent);
          n_errors++;
        end
        if (out_data.sum_significand !== want.sum_significand) begin
          $error("sum_significand exp %h got %h", want.sum_significand,
                 out_data.sum_significand);
          n_errors++;
        end
      end
    end
  end

  task automatic drain();
    while (pending_q.size() > 0 || in_valid) @(posedge clk);
  endtask

  initial begin
    logic [63:0] m;
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0; out_ready = 1'b0;
    n_errors = 0; hold_cycles = 0; stim_done = 1'b0; in_taken = 1'b0;
    send_idle_pct = 16; recv_idle_pct = 47;
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // directed: nans, infinities, zeros, equal magnitudes, extremes
    add_req(0, ExpMax, 64'hC000_0000_0000_0001, 1, ExpMax, 64'hC000_0000_0000_0002);
    add_req(0, 15'h3FFF, IntBit, 1, ExpMax, 64'h8000_0000_0000_0003);
    add_req(0, ExpMax, IntBit, 1, ExpMax, IntBit);
    add_req(1, ExpMax, IntBit, 1, ExpMax, IntBit);
    add_req(1, ExpMax, IntBit, 0, 15'h3FFF, IntBit);
    add_req(0, 15'h3FFF, IntBit, 0, ExpMax, IntBit);
    add_req(1, 15'h0, 64'h0, 1, 15'h0, 64'h1);
    add_req(0, 15'h0, 64'h0, 1, 15'h0, 64'h0);
    add_req(0, 15'h3FFF, 64'hC000_0000_0000_0000, 0, 15'h3FFF, 64'hC000_0000_0000_0000);
    add_req(0, 15'h3FFF, 64'hC000_0000_0000_0000, 1, 15'h3FFF, 64'hC000_0000_0000_0000);
    add_req(0, 15'h7FFE, '1, 0, 15'h7FFE, '1);
    add_req(0, 15'h7FFE, '1, 0, 15'h7FFD, '1);
    add_req(0, 15'h1, IntBit, 1, 15'h1, 64'h8000_0000_0000_0002);
    add_req(0, 15'h3FFF, IntBit, 1, 15'h3FFE, '1);
    add_req(0, 15'h4100, '1, 0, 15'h3FFF, '1);
    add_req(1, 15'h4000, '1, 0, 15'h3FC0, '1);
    add_req(0, 15'h0, 64'h1, 0, 15'h0, 64'h2);
    add_req(1, 15'h0, '1, 1, 15'h0, '1);
    add_req(0, 15'h3FFF, 64'h8000_0000_0000_0001, 1, 15'h3FFF, IntBit);
    add_req(1, ExpMax, '1, 0, 15'h0, 64'h0);
    add_req(0, ExpMax, IntBit, 0, ExpMax, 64'h8000_0000_0000_0005);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 47 : 0;
      recv_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 16 : 0;
      for (int i = 0; i < 330; i++) begin
        m = rand_sig();
        add_req($urandom_range(0, 1), rand_exp(), m, $urandom_range(0, 1), rand_exp(),
                ($urandom_range(0, 3) == 0) ? m : rand_sig());
        // near-equal exponents make cancellation and normalization common
        if ($urandom_range(0, 2) == 0)
          pending_q[$].b_exp = pending_q[$].a_exp ^ 15'($urandom_range(0, 3));
      end
      if (phase == 1) begin
        @(negedge clk) hold_cycles = 60;
      end
      drain();
    end
    stim_done = 1'b1;
  end

  initial begin
    int waited;
    wait (stim_done);
    waited = 0;
    while (expected_sums_q.size() > 0 && waited < 10000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (n_errors == 0 && expected_sums_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/efa_pkg.sv
rtl/efa_align.sv
rtl/efa_addsub.sv
rtl/efa_norm.sv
rtl/extended_float_adder.sv
rtl/efa_checker.sv
tb/sv/extended_float_adder_tb.sv
